FILE: hdl/text_console_writer_defines.svh
// Assertion helpers for the text console writer.
// Both sample on aclk and are disabled while aresetn is low.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
package tcw_pkg;

    // Grid geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int POS_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam int LAST_CELL     = CELL_COUNT - 1;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    // Tab handling
    localparam int TAB_STOP = 4;
    localparam int CNT_W    = $clog2(TAB_STOP + 1);

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [7:0] RESET_COLOR = 8'h07;

    // Word widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_PUT  = 7'b0000100,
        S_COPY = 7'b0001000,
        S_FILL = 7'b0010000,
        S_READ = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

endpackage

FILE: hdl/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS grid of cells (char byte + color byte)
// held in two memories with registered reads, with a cursor.
//
// Input channel (s_*): one word per command. s_tuser carries the command
// (put / clear / read / no-op); s_tdata carries char, read column and row.
// Result channel (m_*): exactly one word per command with the cursor after
// the command, the cell read (zero unless an in-range read) and a scroll flag.
// Config: cfg_wr_en / cfg_wr_data set the blank color used by clear and
// scroll; write it only while the block is idle.
//
// Work per word runs from the accept cycle through the result register load;
// s_tready returns the cycle after. The memories are port bound, one cell/cycle:
// a put writes at most one cell and a read reads one, a tab puts 1 to 4 spaces
// one at a time, a clear sweeps every cell, and a scroll adds a row copy, then
// a bottom fill. After reset the block runs a clearing pass over every cell with
// s_tready low. A result that the receiver does not take sits in the output
// register; the next command is still accepted and worked on, and its result
// waits until the output register is free.
`include "text_console_writer_defines.svh"

module text_console_writer
    import tcw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] char_code, [14:8] read_column, [19:15] read_row, [23:20] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]             s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [6:0] cursor_column, [11:7] cursor_row, [22:12] cursor_position,
    // [30:23] read_char, [38:31] read_color, [39] scrolled
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Control state
    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [POS_W-1:0]    pos_reg, pos_next;        // row * COLUMNS + col, kept incrementally
    logic [ADDR_W-1:0]   scan_reg, scan_next;      // sweep index for copy/fill/init
    logic [CNT_W-1:0]    rem_reg, rem_next;        // characters still to put (tab expands)
    logic [7:0]          chr_reg, chr_next;
    logic                scr_reg, scr_next;
    logic                rdv_reg, rdv_next;        // current command reads a valid cell
    logic                wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [7:0]          blank_color_reg;

    // Output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Cell memories
    logic [7:0]        char_mem  [CELL_COUNT];
    logic [7:0]        color_mem [CELL_COUNT];
    logic [7:0]        q_char_reg, q_color_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              we_char, we_color;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_char, mem_color;

    // Input word fields
    cmd_t              in_cmd;
    logic [7:0]        in_char;
    logic [6:0]        in_col;
    logic [4:0]        in_row;
    logic              in_range;
    logic [ADDR_W-1:0] rd_addr_in;
    logic [CNT_W-1:0]  tab_n;

    // Put arithmetic
    logic              is_nl, is_cr;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [POS_W-1:0]  pos_put;
    logic              put_scroll;

    logic              done;
    logic [7:0]        out_char, out_color;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_char = s_tdata[7:0];
    assign in_col  = s_tdata[14:8];
    assign in_row  = s_tdata[19:15];

    assign in_range   = (32'(in_col) < COLUMNS) && (32'(in_row) < ROWS);
    assign rd_addr_in = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(COLUMNS)) + ADDR_W'(in_col);
    assign tab_n      = CNT_W'(TAB_STOP) - CNT_W'(col_reg % TAB_STOP);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // One character at the cursor: motion, wrap and scroll detection
    always_comb begin
        is_nl   = (chr_reg == CH_NL);
        is_cr   = (chr_reg == CH_CR);
        col_inc = {1'b0, col_reg};
        row_inc = {1'b0, row_reg};
        pos_put = pos_reg;
        if (is_nl) begin
            col_inc = '0;
            row_inc = row_inc + 1'b1;
            pos_put = pos_reg - POS_W'(col_reg) + POS_W'(COLUMNS);
        end else if (is_cr) begin
            col_inc = '0;
            pos_put = pos_reg - POS_W'(col_reg);
        end else begin
            col_inc = col_inc + 1'b1;
            pos_put = pos_reg + 1'b1;
        end
        // wrap keeps pos: (row + 1) * COLUMNS + 0 == pos + 1
        if (col_inc == (COL_W + 1)'(COLUMNS)) begin
            col_inc = '0;
            row_inc = row_inc + 1'b1;
        end
        put_scroll = (row_inc == (ROW_W + 1)'(ROWS));
    end

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        scan_next     = scan_reg;
        rem_next      = rem_reg;
        chr_next      = chr_reg;
        scr_next      = scr_reg;
        rdv_next      = rdv_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_addr_in;
        we_char       = 1'b0;
        we_color      = 1'b0;
        mem_addr      = scan_reg;
        mem_char      = 8'h00;
        mem_color     = blank_color_reg;
        done          = 1'b0;

        case (state_reg)
            S_INIT: begin
                we_char   = 1'b1;
                we_color  = 1'b1;
                mem_color = RESET_COLOR;
                if (scan_reg == ADDR_W'(LAST_CELL)) begin
                    scan_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    scr_next = 1'b0;
                    rdv_next = 1'b0;
                    case (in_cmd)
                        CMD_PUT: begin
                            chr_next   = (in_char == CH_TAB) ? CH_SPACE : in_char;
                            rem_next   = (in_char == CH_TAB) ? tab_n : CNT_W'(1);
                            state_next = S_PUT;
                        end
                        CMD_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            pos_next   = '0;
                            scan_next  = '0;
                            rem_next   = '0;
                            state_next = S_FILL;
                        end
                        CMD_READ: begin
                            rdv_next   = in_range;
                            rd_en      = in_range;
                            state_next = S_READ;
                        end
                        default: begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_PUT: begin
                we_char  = ~is_nl & ~is_cr;
                mem_addr = pos_reg[ADDR_W-1:0];
                mem_char = chr_reg;
                col_next = col_inc[COL_W-1:0];
                row_next = row_inc[ROW_W-1:0];
                pos_next = pos_put;
                rem_next = rem_reg - 1'b1;
                if (put_scroll) begin
                    row_next   = ROW_W'(ROWS - 1);
                    pos_next   = POS_W'(LAST_ROW_BASE) + POS_W'(col_inc[COL_W-1:0]);
                    scr_next   = 1'b1;
                    scan_next  = ADDR_W'(COLUMNS);
                    state_next = S_COPY;
                end else if (rem_reg == CNT_W'(1)) begin
                    done = 1'b1;
                end
            end
            S_COPY: begin
                // read row below, write it back one row up next cycle
                rd_en        = 1'b1;
                rd_addr      = scan_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = scan_reg - ADDR_W'(COLUMNS);
                if (scan_reg == ADDR_W'(LAST_CELL)) begin
                    scan_next  = ADDR_W'(LAST_ROW_BASE);
                    state_next = S_FILL;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_FILL: begin
                // wait out the last copy write before sweeping
                if (!wr_pend_reg) begin
                    we_char  = 1'b1;
                    we_color = 1'b1;
                    if (scan_reg == ADDR_W'(LAST_CELL)) begin
                        if (rem_reg == '0) begin
                            done = 1'b1;
                        end else begin
                            state_next = S_PUT;
                        end
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            S_READ: begin
                done = 1'b1;
            end
            S_DONE: begin
                done = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_pend_reg) begin
            we_char   = 1'b1;
            we_color  = 1'b1;
            mem_addr  = wr_addr_reg;
            mem_char  = q_char_reg;
            mem_color = q_color_reg;
        end

        out_char  = rdv_reg ? q_char_reg  : 8'h00;
        out_color = rdv_reg ? q_color_reg : 8'h00;

        if (done) begin
            if (!m_tvalid_reg || m_tready) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {scr_next, out_color, out_char, 11'(pos_next),
                                 5'(row_next), 7'(col_next)};
                state_next    = S_IDLE;
            end else begin
                state_next = S_DONE;
            end
        end
    end

    // Cell memories: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we_char) begin
            char_mem[mem_addr] <= mem_char;
        end
        if (we_color) begin
            color_mem[mem_addr] <= mem_color;
        end
        if (rd_en) begin
            q_char_reg  <= char_mem[rd_addr];
            q_color_reg <= color_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_INIT;
            col_reg         <= '0;
            row_reg         <= '0;
            pos_reg         <= '0;
            scan_reg        <= '0;
            rem_reg         <= '0;
            scr_reg         <= 1'b0;
            rdv_reg         <= 1'b0;
            wr_pend_reg     <= 1'b0;
            blank_color_reg <= RESET_COLOR;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pos_reg      <= pos_next;
            scan_reg     <= scan_next;
            rem_reg      <= rem_next;
            scr_reg      <= scr_next;
            rdv_reg      <= rdv_next;
            wr_pend_reg  <= wr_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                blank_color_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        chr_reg     <= chr_next;
        wr_addr_reg <= wr_addr_next;
        m_tdata_reg <= m_tdata_next;
    end

    `TCW_ASSERT_NOW(a_cursor_in_grid, 1'b1, (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS), "cursor outside the grid")
    `TCW_ASSERT_NOW(a_pos_tracks_cursor, 1'b1, 32'(pos_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg), "linear position out of step with cursor")
    `TCW_ASSERT_NEXT(a_copy_writes_back, state_reg == S_COPY, wr_pend_reg && (32'(wr_addr_reg) + COLUMNS < CELL_COUNT), "row copy lost its write-back")

endmodule
